/* rtl/mjda_pkg.sv */
`default_nettype none
package mjda_pkg;

  localparam int COORD_W   = 16;
  localparam int MAX_ITEMS = 65536;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int RAD_W     = SQ_W + 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SUM_W     = 33;
  localparam int CNT_W     = 17;
  localparam int OUT_W     = 17;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ITEMS);

  typedef struct packed {
    logic signed [COORD_W-1:0] pred_x;
    logic signed [COORD_W-1:0] pred_y;
    logic signed [COORD_W-1:0] pred_z;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] ref_z;
    logic                      last_joint;
  } joint_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean_error;
    logic [OUT_W-1:0] joint_total;
    logic             count_overflow;
  } result_t;

  // start strobe type used by both iterative units
  typedef struct packed {
    logic start;
  } unit_ctl_t;

endpackage
`default_nettype wire

/* rtl/mjda_lane.sv */
`default_nettype none
module mjda_lane (
  input  wire logic                                 clk,
  input  wire logic                                 load,
  input  wire logic signed [mjda_pkg::COORD_W-1:0] pred,
  input  wire logic signed [mjda_pkg::COORD_W-1:0] refc,
  output logic             [mjda_pkg::SQ_W-1:0]    square
);

  logic signed [mjda_pkg::DIFF_W-1:0] diff;
  logic        [mjda_pkg::DIFF_W-1:0] mag;
  logic        [2*mjda_pkg::DIFF_W-1:0] prod;

  always_comb begin
    diff = mjda_pkg::DIFF_W'(pred) - mjda_pkg::DIFF_W'(refc);
    mag  = diff[mjda_pkg::DIFF_W-1] ? mjda_pkg::DIFF_W'(-diff) : mjda_pkg::DIFF_W'(diff);
    prod = mag * mag;
  end

  // |diff| is at most 2^COORD_W - 1, so the square fits SQ_W bits
  always_ff @(posedge clk) begin
    if (load) begin
      square <= prod[mjda_pkg::SQ_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/mjda_sqrt.sv */
`default_nettype none
module mjda_sqrt (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mjda_pkg::unit_ctl_t             ctl,
  input  wire logic [mjda_pkg::RAD_W-1:0]      radicand,
  output logic [mjda_pkg::ROOT_W-1:0]          root,
  output logic                                 done
);

  localparam int REM_W = mjda_pkg::ROOT_W + 3;

  logic [mjda_pkg::RAD_W-1:0] x;
  logic [REM_W-1:0]           rem;
  logic [4:0]                 cnt;
  logic                       busy;
  logic [REM_W-1:0]           rem_shift;
  logic [REM_W-1:0]           trial;

  always_comb begin
    rem_shift = {rem[REM_W-3:0], x[mjda_pkg::RAD_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
  end

  // two radicand bits, one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        x    <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= 5'(mjda_pkg::ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        x <= {x[mjda_pkg::RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
          rem  <= rem_shift - trial;
          root <= {root[mjda_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[mjda_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/mjda_div.sv */
`default_nettype none
module mjda_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mjda_pkg::unit_ctl_t          ctl,
  input  wire logic [mjda_pkg::SUM_W-1:0]   dividend,
  input  wire logic [mjda_pkg::CNT_W-1:0]   divisor,
  output logic [mjda_pkg::SUM_W-1:0]        quotient,
  output logic                              done
);

  localparam int REM_W = mjda_pkg::CNT_W + 1;

  logic [REM_W-1:0]          rem;
  logic [mjda_pkg::CNT_W-1:0] dsr;
  logic [5:0]                cnt;
  logic                      busy;
  logic [REM_W-1:0]          rem_shift;

  always_comb begin
    rem_shift = {rem[REM_W-2:0], quotient[mjda_pkg::SUM_W-1]};
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        cnt      <= 6'(mjda_pkg::SUM_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (rem_shift >= REM_W'(dsr)) begin
          rem      <= rem_shift - REM_W'(dsr);
          quotient <= {quotient[mjda_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem      <= rem_shift;
          quotient <= {quotient[mjda_pkg::SUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/mean_joint_distance_accumulator_top.sv */
`default_nettype none
// Channel  | Handshake                   | Payload             | Dir
// joint    | joint_valid / joint_stall   | mjda_pkg::joint_t   | in
// result   | result_valid / result_stall | mjda_pkg::result_t  | out
//
// A request runs from accept to the next accept through lane load, root
// start, the root, accumulate and idle; one marked last then goes on through
// divide start, the divide, its finish and the result load.
// The root and divide units are iterative.
// rst is synchronous and clears sum, count, overflow flag and control.
// joint_stall is high whenever a request is in progress.
// A finished result waits in its register while the next request is taken.
module mean_joint_distance_accumulator_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                joint_valid,
  output logic                     joint_stall,
  input  wire mjda_pkg::joint_t    joint,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output mjda_pkg::result_t        result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_DST  = 3'd6;

  logic [2:0] state;
  logic       accept;
  logic       last;

  logic [mjda_pkg::SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [mjda_pkg::RAD_W-1:0]  sq_sum;
  logic [mjda_pkg::ROOT_W-1:0] root_dist;
  logic                        root_done;
  logic [mjda_pkg::SUM_W-1:0]  quot;
  logic                        div_done;
  mjda_pkg::unit_ctl_t         sqrt_ctl, div_ctl;

  logic [mjda_pkg::SUM_W-1:0]  distance_sum;
  logic [mjda_pkg::CNT_W-1:0]  joint_count;
  logic                        overflow_seen;
  logic [mjda_pkg::SUM_W:0]    sum_wide;
  logic [mjda_pkg::SUM_W-1:0]  sum_next;
  logic                        out_free;

  assign accept      = joint_valid && !joint_stall;
  assign joint_stall = (state != S_IDLE);
  assign out_free    = !result_valid || !result_stall;

  // one lane per axis
  mjda_lane u_lane_x (.clk, .load(accept), .pred(joint.pred_x), .refc(joint.ref_x),
                      .square(sq_x));
  mjda_lane u_lane_y (.clk, .load(accept), .pred(joint.pred_y), .refc(joint.ref_y),
                      .square(sq_y));
  mjda_lane u_lane_z (.clk, .load(accept), .pred(joint.pred_z), .refc(joint.ref_z),
                      .square(sq_z));

  // merge: three squares into the root radicand
  assign sq_sum = mjda_pkg::RAD_W'(sq_x) + mjda_pkg::RAD_W'(sq_y)
                + mjda_pkg::RAD_W'(sq_z);

  assign sqrt_ctl.start = (state == S_SQ);
  // divide starts once sum and count hold the last joint
  assign div_ctl.start  = (state == S_DST);

  mjda_sqrt u_sqrt (.clk, .rst, .ctl(sqrt_ctl), .radicand(sq_sum), .root(root_dist),
                    .done(root_done));

  mjda_div u_div (.clk, .rst, .ctl(div_ctl), .dividend(distance_sum),
                  .divisor(joint_count), .quotient(quot), .done(div_done));

  // saturating accumulate
  always_comb begin
    sum_wide = (mjda_pkg::SUM_W+1)'(distance_sum) + (mjda_pkg::SUM_W+1)'(root_dist);
    sum_next = sum_wide[mjda_pkg::SUM_W] ? mjda_pkg::SUM_MAX
                                         : sum_wide[mjda_pkg::SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last <= joint.last_joint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      distance_sum  <= '0;
      joint_count   <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      // S_OUT reloads the register itself
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          // count full: joint dropped and flagged
          if (joint_count == mjda_pkg::CNT_LIMIT) begin
            overflow_seen <= 1'b1;
          end else begin
            joint_count  <= joint_count + mjda_pkg::CNT_W'(1);
            distance_sum <= sum_next;
          end
          state <= last ? S_DST : S_IDLE;
        end
        S_DST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            result.mean_error     <= (joint_count == '0) ? '0
                                     : quot[mjda_pkg::OUT_W-1:0];
            result.joint_total    <= joint_count[mjda_pkg::OUT_W-1:0];
            result.count_overflow <= overflow_seen;
            result_valid          <= 1'b1;
            distance_sum          <= '0;
            joint_count           <= '0;
            overflow_seen         <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mjda_checker.sv */
`default_nettype none
module mjda_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              joint_valid,
  input wire logic              joint_stall,
  input wire mjda_pkg::joint_t  joint,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire mjda_pkg::result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  a_total: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.joint_total != '0)
    else $error("result with no joints");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.count_overflow
      |-> result.joint_total == mjda_pkg::OUT_W'(mjda_pkg::MAX_ITEMS))
    else $error("overflow flagged below the count limit");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    joint_valid && !joint_stall |=> joint_stall)
    else $error("request taken with no time to process");

  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

endmodule

bind mean_joint_distance_accumulator_top mjda_checker u_mjda_checker (
  .clk, .rst, .joint_valid, .joint_stall, .joint, .result_valid, .result_stall, .result
);
`default_nettype wire
